@@ rtl/lsbw_pkg.sv @@
package lsbw_pkg;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_SKIP  = 2'd1;
	localparam logic [1:0] OP_ALIGN = 2'd2;
	localparam logic [1:0] OP_FLUSH = 2'd3;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned CNT_W  = 11;
	localparam int unsigned WIDX_W = 16;

	localparam logic [CNT_W-1:0]  PUT_MAX_BITS  = 11'd64;
	localparam logic [CNT_W-1:0]  SKIP_MAX_BITS = 11'd1024;
	localparam logic [WIDX_W-1:0] CAP_RESET     = 16'd400;

	typedef logic [WORD_W-1:0] word_t;

endpackage

@@ rtl/lsb_first_bitstream_writer_top.sv @@
// LSB-first bit packer into 64-bit words. Put appends up to 64 bits of a
// value, skip appends up to 1024 zero bits, align pads with ones or zeros to
// a power-of-two bit boundary counted from word 0, and flush emits the partial
// word zero-padded and restarts at word 0. Words at or beyond capacity_words
// (APB register at address 0, reset 400) are dropped. One item is taken at a
// time: after accept, a single 128-bit shifter places one chunk of at most
// 64 bits per cycle while no held word stalls it, and the next item is
// taken only after the current one completes.
// Each completed word waits in one output register; a held word stalls the
// next chunk that completes a word and any flush. last_of_item marks the final
// word of an item.
module lsb_first_bitstream_writer_top
	import lsbw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [63:0]       data_value,
	input  logic [10:0]       bit_count,
	input  logic              fill_ones,

	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       out_word,
	output logic [15:0]       word_index,
	output logic              last_of_item,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [1:0]        op_q;
	word_t             pat_q;
	logic [CNT_W-1:0]  n_q;
	word_t             partial_q;
	logic [POS_W-1:0]  bitpos_q;
	logic [WIDX_W-1:0] word_count_q;
	logic [WIDX_W-1:0] capacity_q;

	logic              out_valid_q;
	word_t             out_word_q;
	logic [WIDX_W-1:0] word_index_q;
	logic              last_q;

	logic              in_fire;
	logic              cfg_wr;
	logic              full;
	logic              slot_free;
	logic [6:0]        chunk;
	word_t             mask;
	word_t             v;
	logic [127:0]      shifted;
	logic [6:0]        sum;
	logic              wraps;
	logic [CNT_W-1:0]  n_rem;
	logic [WIDX_W:0]   wc_next;
	logic              more;
	logic              chunk_go;
	logic              step_chunk;
	logic              emit_chunk;
	logic              flush_go;
	logic              emit_flush;
	logic              run_done;
	logic [CNT_W-1:0]  align_m;
	logic [CNT_W-1:0]  align_tot;
	logic [CNT_W-1:0]  align_pad;
	logic              align_ok;
	logic [CNT_W-1:0]  load_n;
	word_t             load_pat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && !paddr[2];
	assign prdata    = paddr[2] ? 32'd0 : {16'd0, capacity_q};

	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign word_index   = word_index_q;
	assign last_of_item = last_q;

	assign full      = (word_count_q >= capacity_q);
	assign slot_free = !out_valid_q || out_ready;

	// shared datapath: mask, place at cursor, split into low and carry words
	assign chunk   = (n_q > PUT_MAX_BITS) ? 7'd64 : n_q[6:0];
	assign mask    = chunk[6] ? '1 : ~({WORD_W{1'b1}} << chunk[5:0]);
	assign v       = pat_q & mask;
	assign shifted = {64'd0, v} << bitpos_q;
	assign sum     = {1'b0, bitpos_q} + chunk;
	assign wraps   = sum[6];
	assign n_rem   = n_q - {4'd0, chunk};
	assign wc_next = {1'b0, word_count_q} + 17'd1;
	assign more    = (({5'd0, sum[5:0]} + n_rem) >= 11'd64) &&
	                 (wc_next < {1'b0, capacity_q});

	assign chunk_go   = (state_q == ST_RUN) && (op_q != OP_FLUSH) && (n_q != '0) && !full;
	assign step_chunk = chunk_go && (!wraps || slot_free);
	assign emit_chunk = chunk_go && wraps && slot_free;
	assign flush_go   = (state_q == ST_RUN) && (op_q == OP_FLUSH) && slot_free;
	assign emit_flush = flush_go && (bitpos_q != '0) && !full;
	assign run_done   = (state_q == ST_RUN) &&
	                    (((op_q != OP_FLUSH) && ((n_q == '0) || full)) || flush_go ||
	                     (step_chunk && (n_rem == '0)));

	// align pad from the low ten bits of the absolute bit position
	assign align_m   = bit_count - 11'd1;
	assign align_tot = {word_count_q[4:0], bitpos_q};
	assign align_pad = (bit_count - (align_tot & align_m)) & align_m;
	assign align_ok  = (bit_count != '0) && ((bit_count & align_m) == '0);

	always_comb begin
		load_n   = '0;
		load_pat = '0;
		case (op)
			OP_PUT: begin
				load_pat = data_value;
				load_n   = (bit_count > PUT_MAX_BITS) ? PUT_MAX_BITS : bit_count;
			end
			OP_SKIP: begin
				load_n = (bit_count > SKIP_MAX_BITS) ? SKIP_MAX_BITS : bit_count;
			end
			OP_ALIGN: begin
				load_pat = fill_ones ? '1 : '0;
				load_n   = align_ok ? align_pad : '0;
			end
			default: begin
				load_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			partial_q    <= '0;
			bitpos_q     <= '0;
			word_count_q <= '0;
			capacity_q   <= CAP_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr)
				capacity_q <= pwdata[15:0];

			if (in_fire) begin
				state_q <= ST_RUN;
				n_q     <= load_n;
			end else if (run_done) begin
				state_q <= ST_IDLE;
			end

			if (step_chunk) begin
				n_q <= n_rem;
				if (wraps) begin
					partial_q    <= shifted[127:64];
					bitpos_q     <= sum[5:0];
					word_count_q <= wc_next[WIDX_W-1:0];
				end else begin
					partial_q <= partial_q | shifted[63:0];
					bitpos_q  <= sum[5:0];
				end
			end else if (flush_go) begin
				partial_q    <= '0;
				bitpos_q     <= '0;
				word_count_q <= '0;
			end

			if (emit_chunk || emit_flush)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= op;
			pat_q <= load_pat;
		end
		if (emit_chunk) begin
			out_word_q   <= partial_q | shifted[63:0];
			word_index_q <= word_count_q;
			last_q       <= !more;
		end else if (emit_flush) begin
			out_word_q   <= partial_q;
			word_index_q <= word_count_q;
			last_q       <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_RUN))
		else $error("accepted beat did not start the sequencer");

	a_partial_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((partial_q >> bitpos_q) == '0))
		else $error("partial word has bits above cursor");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit_chunk |=> (word_count_q == $past(word_count_q) + 16'd1))
		else $error("word count did not advance on emitted word");

	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		flush_go |=> ((word_count_q == '0) && (bitpos_q == '0) && (state_q == ST_IDLE)))
		else $error("flush did not restart the buffer");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_chunk || emit_flush) |=> out_valid_q)
		else $error("emitted word lost");
`endif

endmodule

@@ test/lsb_first_bitstream_writer_top_tb.sv @@
import lsbw_pkg::*;

typedef struct packed {
	word_t       data;
	logic [15:0] idx;
	logic        last;
} packed_word_t;

class bitpack_scoreboard;
	localparam int unsigned MAX_REPORTS = 10;

	word_t        acc;
	int unsigned  fill_pos;
	int unsigned  words_done;
	int unsigned  cap;
	packed_word_t words_due[$];
	packed_word_t batch[16];
	int unsigned  batch_n;
	int unsigned  faults;

	function new();
		acc = '0;
		fill_pos = 0;
		words_done = 0;
		cap = CAP_RESET;
		batch_n = 0;
		faults = 0;
	endfunction

	function void set_capacity(logic [15:0] v);
		cap = v;
	endfunction

	function int unsigned pending();
		return words_due.size();
	endfunction

	function bit full();
		return words_done >= cap;
	endfunction

	function void stash(word_t w);
		if (batch_n < 16) begin
			batch[batch_n].data = w;
			batch[batch_n].idx = words_done[15:0];
			batch[batch_n].last = 1'b0;
			batch_n++;
		end
	endfunction

	function void append(word_t v, int unsigned n);
		int unsigned spill;
		int unsigned rest;
		if (n == 0 || n > 64 || full())
			return;
		if (n < 64)
			v &= (64'd1 << n) - 64'd1;
		acc |= v << fill_pos;
		if (fill_pos + n < 64) begin
			fill_pos += n;
			return;
		end
		stash(acc);
		words_done++;
		spill = 64 - fill_pos;
		rest = fill_pos + n - 64;
		acc = (rest > 0 && spill < 64) ? (v >> spill) : '0;
		fill_pos = rest & 63;
	endfunction

	function void run(word_t pattern, int unsigned n);
		int unsigned chunk;
		while (n > 0 && !full()) begin
			chunk = (n > 64) ? 64 : n;
			append(pattern, chunk);
			n -= chunk;
		end
	endfunction

	// predict the words caused by one accepted input beat
	function void pack_item(logic [1:0] opc, word_t d, logic [10:0] cnt, logic ones);
		int unsigned c;
		int unsigned total;
		int unsigned pad;
		batch_n = 0;
		c = cnt;
		case (opc)
			OP_PUT: begin
				if (c > PUT_MAX_BITS)
					c = PUT_MAX_BITS;
				append(d, c);
			end
			OP_SKIP: begin
				if (c > SKIP_MAX_BITS)
					c = SKIP_MAX_BITS;
				run('0, c);
			end
			OP_ALIGN: begin
				if (c != 0 && (c & (c - 1)) == 0 && !full()) begin
					total = words_done * 64 + fill_pos;
					pad = (c - (total & (c - 1))) & (c - 1);
					run(ones ? '1 : '0, pad);
				end
			end
			default: begin
				if (fill_pos > 0 && !full())
					stash(acc);
				acc = '0;
				fill_pos = 0;
				words_done = 0;
			end
		endcase
		for (int unsigned i = 0; i < batch_n; i++) begin
			batch[i].last = (i == batch_n - 1);
			words_due.push_back(batch[i]);
		end
	endfunction

	function void check_word(word_t w, logic [15:0] idx, logic last);
		packed_word_t e;
		if (words_due.size() == 0) begin
			faults++;
			if (faults <= MAX_REPORTS)
				$display("unexpected beat: word %h idx %0d last %0b", w, idx, last);
			return;
		end
		e = words_due.pop_front();
		if (e.data !== w || e.idx !== idx || e.last !== last) begin
			faults++;
			if (faults <= MAX_REPORTS)
				$display("mismatch: expected word %h idx %0d last %0b, got word %h idx %0d last %0b",
					e.data, e.idx, e.last, w, idx, last);
		end
	endfunction
endclass

module lsb_first_bitstream_writer_top_tb;
	localparam logic [2:0] CAPACITY_ADDR = 3'd0;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [63:0] data_value;
	logic [10:0] bit_count;
	logic        fill_ones;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] out_word;
	logic [15:0] word_index;
	logic        last_of_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit quiet;
	bitpack_scoreboard sb = new();

	lsb_first_bitstream_writer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.data_value(data_value),
		.bit_count(bit_count),
		.fill_ones(fill_ones),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.word_index(word_index),
		.last_of_item(last_of_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.pack_item(op, data_value, bit_count, fill_ones);
		if (out_valid && out_ready)
			sb.check_word(out_word, word_index, last_of_item);
	end

	initial begin : watchdog
		int unsigned stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				stall = 0;
			else
				stall++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (quiet) begin
				out_ready = 1'b1;
				@(negedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end
		end
	end

	// all driver tasks start and end on a falling edge
	task automatic send_beat(logic [1:0] opc, word_t d, logic [10:0] cnt, logic ones);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		op = opc;
		data_value = d;
		bit_count = cnt;
		fill_ones = ones;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_capacity(logic [15:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CAPACITY_ADDR;
		pwdata = {16'h0, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_capacity(v);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_random();
		logic [1:0]  o;
		word_t       d;
		logic [10:0] c;
		logic        f;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		d = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: d = '0;
			1: d = '1;
			default: ;
		endcase
		c = 11'($urandom_range(0, 2047));
		f = 1'($urandom_range(0, 1));
		if (pick < 50) begin
			o = OP_PUT;
			if ($urandom_range(0, 6) != 0)
				c = 11'($urandom_range(0, 64));
		end else if (pick < 68) begin
			o = OP_SKIP;
			case ($urandom_range(0, 9))
				0: ;
				1, 2: c = 11'($urandom_range(131, 1024));
				default: c = 11'($urandom_range(0, 130));
			endcase
		end else if (pick < 88) begin
			o = OP_ALIGN;
			if ($urandom_range(0, 4) != 0)
				c = 11'd1 << $urandom_range(0, 10);
		end else begin
			o = OP_FLUSH;
		end
		send_beat(o, d, c, f);
	endtask

	task automatic run_random(int unsigned n, bit with_pause);
		for (int unsigned i = 0; i < n; i++) begin
			if (with_pause && i % 40 == 39)
				drain();
			send_random();
		end
	endtask

	initial begin
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PUT;
		data_value = '0;
		bit_count = '0;
		fill_ones = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = CAPACITY_ADDR;
		pwdata = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero counts, widest fields, oversize counts, bad boundaries
		send_beat(OP_PUT, '1, 11'd0, 1'b0);
		send_beat(OP_SKIP, '1, 11'd0, 1'b1);
		send_beat(OP_PUT, '1, 11'd64, 1'b0);
		send_beat(OP_PUT, 64'd5, 11'd3, 1'b0);
		send_beat(OP_PUT, 64'hA5A5_5A5A_F00F_0FF0, 11'd64, 1'b0);
		send_beat(OP_PUT, 64'h0123_4567_89AB_CDEF, 11'd2047, 1'b1);
		send_beat(OP_PUT, '1, 11'd1, 1'b0);
		send_beat(OP_ALIGN, '0, 11'd0, 1'b1);
		send_beat(OP_ALIGN, '0, 11'd3, 1'b1);
		send_beat(OP_ALIGN, '0, 11'd1, 1'b1);
		send_beat(OP_ALIGN, '0, 11'd2, 1'b1);
		send_beat(OP_ALIGN, '0, 11'd64, 1'b1);
		send_beat(OP_ALIGN, '1, 11'd1024, 1'b0);
		send_beat(OP_PUT, 64'h1F, 11'd5, 1'b0);
		send_beat(OP_ALIGN, '0, 11'd1024, 1'b1);
		send_beat(OP_SKIP, '0, 11'd5, 1'b0);
		send_beat(OP_SKIP, '0, 11'd1024, 1'b0);
		send_beat(OP_SKIP, '1, 11'd2047, 1'b1);
		send_beat(OP_FLUSH, '1, 11'd2047, 1'b1);
		send_beat(OP_FLUSH, '0, 11'd0, 1'b0);
		send_beat(OP_PUT, '1, 11'd63, 1'b0);
		send_beat(OP_ALIGN, '0, 11'd1024, 1'b1);
		send_beat(OP_FLUSH, '0, 11'd0, 1'b0);

		// buffer fills mid-stream, then flush recovers
		write_capacity(16'd2);
		send_beat(OP_PUT, '1, 11'd40, 1'b0);
		send_beat(OP_PUT, 64'hDEAD_BEEF_CAFE_F00D, 11'd64, 1'b0);
		send_beat(OP_PUT, '1, 11'd64, 1'b0);
		send_beat(OP_ALIGN, '0, 11'd64, 1'b1);
		send_beat(OP_SKIP, '0, 11'd100, 1'b0);
		send_beat(OP_FLUSH, '0, 11'd0, 1'b0);
		send_beat(OP_PUT, '1, 11'd64, 1'b0);

		write_capacity(16'($urandom_range(3, 8)));
		run_random(50, 1'b0);

		write_capacity(16'd0);
		run_random(25, 1'b0);

		write_capacity(16'hFFFF);
		run_random(150, 1'b1);

		// likely below the current word count, so the buffer is full at once
		write_capacity(16'd1);
		run_random(25, 1'b0);

		write_capacity(16'($urandom_range(200, 1000)));
		quiet = 1'b1;
		run_random(100, 1'b0);

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.faults == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/lsbw_pkg.sv
rtl/lsb_first_bitstream_writer_top.sv
test/lsb_first_bitstream_writer_top_tb.sv
